// ===== rtl/psdf_pkg.sv =====
// ----------------------------------------------------------------------------
// psdf_pkg : shared types and constants of the primitive SDF evaluator
// Shape codes, register indexes, root pipeline sizing and side-band record.
// ----------------------------------------------------------------------------
package psdf_pkg;

  // shape codes
  localparam logic [2:0] SHAPE_BOX     = 3'd0;
  localparam logic [2:0] SHAPE_SPHERE  = 3'd1;
  localparam logic [2:0] SHAPE_TORUS   = 3'd2;
  localparam logic [2:0] SHAPE_CYL     = 3'd3;
  localparam logic [2:0] SHAPE_HSPHERE = 3'd4;
  localparam logic [2:0] SHAPE_HBOX    = 3'd5;

  // register indexes
  localparam logic [2:0] REG_SHAPE = 3'd0;
  localparam logic [2:0] REG_INV   = 3'd1;
  localparam logic [2:0] REG_TOL   = 3'd2;
  localparam logic [2:0] REG_SIZEA = 3'd3;
  localparam logic [2:0] REG_SIZEB = 3'd4;
  localparam logic [2:0] REG_SIZEC = 3'd5;
  localparam logic [2:0] REG_SHELL = 3'd6;

  // root of a 64-bit radicand: one result bit per stage
  localparam int SQ_STEPS = 32;
  localparam int REM_W    = 35;

  // data travelling alongside the radicand
  typedef struct packed {
    logic [2:0]         shape;
    logic signed [33:0] inner;   // clamped interior maximum (box shapes)
    logic signed [33:0] dy;      // |y| - size_b
    logic [31:0]        ay;      // |y|
    logic [31:0]        r1;      // first root
    logic signed [33:0] q;       // r1 - size_a
  } psdf_side_t;

endpackage

// ===== rtl/psdf_isqrt.sv =====
// ----------------------------------------------------------------------------
// psdf_isqrt : pipelined floor square root
// 64-bit radicand, 32-bit root, one root bit resolved per register stage.
// ----------------------------------------------------------------------------
module psdf_isqrt (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [63:0]          in_rad,
  input  psdf_pkg::psdf_side_t in_side,
  output logic                 out_vld,
  output logic [31:0]          out_root,
  output psdf_pkg::psdf_side_t out_side
);
  import psdf_pkg::*;

  logic             vld_r  [SQ_STEPS];
  logic [REM_W-1:0] rem_r  [SQ_STEPS];
  logic [31:0]      root_r [SQ_STEPS];
  logic [63:0]      rad_r  [SQ_STEPS];
  psdf_side_t       side_r [SQ_STEPS];

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
    logic             vld_in;
    logic [REM_W-1:0] rem_in;
    logic [31:0]      root_in;
    logic [63:0]      rad_in;
    psdf_side_t       side_in;
    logic [REM_W-1:0] cand;
    logic [REM_W-1:0] trial;
    logic             fit;

    if (i == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_rad;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign rad_in  = rad_r[i-1];
      assign side_in = side_r[i-1];
    end

    assign cand  = {rem_in[REM_W-3:0], rad_in[63:62]};
    assign trial = {{(REM_W-34){1'b0}}, root_in, 2'b01};
    assign fit   = cand >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= fit ? (cand - trial) : cand;
        root_r[i] <= {root_in[30:0], fit};
        rad_r[i]  <= {rad_in[61:0], 2'b00};
        side_r[i] <= side_in;
      end
    end
  end

  assign out_vld  = vld_r[SQ_STEPS-1];
  assign out_root = root_r[SQ_STEPS-1];
  assign out_side = side_r[SQ_STEPS-1];

endmodule

// ===== rtl/primitive_sdf_eval.sv =====
// ----------------------------------------------------------------------------
// primitive_sdf_eval : signed distance of a point to a configured primitive
// Box, sphere, torus, Y-axis cylinder and hollow shells, Q16.16 fixed point,
// exact floor roots, saturated result.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  in_     | in        | in_valid / in_stall | point_x, point_y, point_z
//  out_    | out       | out_valid/out_stall | signed_distance, saturated
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One beat per cycle in and out while no result is stalled. The depth
//  is set by the two root pipelines, each resolving one root bit per stage.
//  Reset clears every valid bit and loads the register defaults; no flush.
//  A stalled result freezes the whole pipeline and in_stall rises in the same
//  cycle, so nothing is dropped or repeated. cfg_ready is always high.
// ----------------------------------------------------------------------------
module primitive_sdf_eval #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // input points
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  // results
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_signed_distance,
  output logic               out_saturated,
  // register writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import psdf_pkg::*;

  localparam logic [30:0] UNIT = 31'(1) << FRAC_BITS;

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  logic [2:0]         shape_r;
  logic               inv_r;
  logic signed [31:0] tol_r;
  logic [30:0]        size_a_r, size_b_r, size_c_r, shell_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r  <= SHAPE_BOX;
      inv_r    <= 1'b0;
      tol_r    <= '0;
      size_a_r <= UNIT;
      size_b_r <= UNIT;
      size_c_r <= UNIT;
      shell_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SHAPE: shape_r  <= cfg_data[2:0];
        REG_INV:   inv_r    <= cfg_data[0];
        REG_TOL:   tol_r    <= cfg_data;
        REG_SIZEA: size_a_r <= cfg_data[30:0];
        REG_SIZEB: size_b_r <= cfg_data[30:0];
        REG_SIZEC: size_c_r <= cfg_data[30:0];
        REG_SHELL: shell_r  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // global advance: freeze every pipeline stage while a result waits
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // --------------------------------------------------------------------------
  // S1: magnitudes, per-axis excess, first norm operands
  // --------------------------------------------------------------------------
  logic [31:0]        ax, ay, az, pdx, pdy, pdz;
  logic signed [33:0] dx, dy, dz, mxy, mx;
  logic [31:0]        o0, o1, o2;

  assign ax  = in_point_x[31] ? (~in_point_x + 32'd1) : in_point_x;
  assign ay  = in_point_y[31] ? (~in_point_y + 32'd1) : in_point_y;
  assign az  = in_point_z[31] ? (~in_point_z + 32'd1) : in_point_z;
  assign dx  = $signed({2'b00, ax}) - $signed({3'b000, size_a_r});
  assign dy  = $signed({2'b00, ay}) - $signed({3'b000, size_b_r});
  assign dz  = $signed({2'b00, az}) - $signed({3'b000, size_c_r});
  assign pdx = dx[33] ? 32'd0 : dx[31:0];
  assign pdy = dy[33] ? 32'd0 : dy[31:0];
  assign pdz = dz[33] ? 32'd0 : dz[31:0];
  assign mxy = (dx > dy) ? dx : dy;
  assign mx  = (mxy > dz) ? mxy : dz;

  always_comb begin
    case (shape_r)
      SHAPE_SPHERE, SHAPE_HSPHERE: begin
        o0 = ax; o1 = ay; o2 = az;
      end
      SHAPE_TORUS, SHAPE_CYL: begin
        o0 = ax; o1 = 32'd0; o2 = az;
      end
      default: begin
        o0 = pdx; o1 = pdy; o2 = pdz;
      end
    endcase
  end

  logic        s1_vld_r;
  logic [31:0] s1_o0_r, s1_o1_r, s1_o2_r;
  psdf_side_t  s1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (en) s1_vld_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_o0_r         <= o0;
      s1_o1_r         <= o1;
      s1_o2_r         <= o2;
      s1_side_r.shape <= shape_r;
      s1_side_r.inner <= mx[33] ? mx : 34'sd0;
      s1_side_r.dy    <= dy;
      s1_side_r.ay    <= ay;
      s1_side_r.r1    <= '0;
      s1_side_r.q     <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // S2: squares, S3: sum of squares
  // --------------------------------------------------------------------------
  logic        s2_vld_r, s3_vld_r;
  logic [63:0] s2_p0_r, s2_p1_r, s2_p2_r, s3_sum_r;
  psdf_side_t  s2_side_r, s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_p0_r   <= 64'(s1_o0_r) * 64'(s1_o0_r);
      s2_p1_r   <= 64'(s1_o1_r) * 64'(s1_o1_r);
      s2_p2_r   <= 64'(s1_o2_r) * 64'(s1_o2_r);
      s2_side_r <= s1_side_r;
      s3_sum_r  <= s2_p0_r + s2_p1_r + s2_p2_r;
      s3_side_r <= s2_side_r;
    end
  end

  // first root
  logic        q1_vld;
  logic [31:0] q1_root;
  psdf_side_t  q1_side;

  psdf_isqrt u_root1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s3_vld_r),
    .in_rad   (s3_sum_r),
    .in_side  (s3_side_r),
    .out_vld  (q1_vld),
    .out_root (q1_root),
    .out_side (q1_side)
  );

  // --------------------------------------------------------------------------
  // S4: q = r1 - size_a, second norm operands (torus, cylinder)
  // --------------------------------------------------------------------------
  logic signed [33:0] q, nq;
  logic [31:0]        aq, pq, pdy2, t0, t1;
  psdf_side_t         s4_side_nxt;

  assign q    = $signed({2'b00, q1_root}) - $signed({3'b000, size_a_r});
  assign nq   = -q;
  assign aq   = q[33] ? nq[31:0] : q[31:0];
  assign pq   = q[33] ? 32'd0 : q[31:0];
  assign pdy2 = q1_side.dy[33] ? 32'd0 : q1_side.dy[31:0];

  always_comb begin
    case (q1_side.shape)
      SHAPE_TORUS: begin t0 = aq; t1 = q1_side.ay; end
      SHAPE_CYL:   begin t0 = pq; t1 = pdy2;       end
      default:     begin t0 = 32'd0; t1 = 32'd0;   end
    endcase
  end

  // side record picks up the first root and q here
  always_comb begin
    s4_side_nxt    = q1_side;
    s4_side_nxt.r1 = q1_root;
    s4_side_nxt.q  = q;
  end

  logic        s4_vld_r, s5_vld_r, s6_vld_r;
  logic [31:0] s4_t0_r, s4_t1_r;
  logic [63:0] s5_p0_r, s5_p1_r, s6_sum_r;
  psdf_side_t  s4_side_r, s5_side_r, s6_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= q1_vld;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_t0_r      <= t0;
      s4_t1_r      <= t1;
      s4_side_r    <= s4_side_nxt;
      s5_p0_r      <= 64'(s4_t0_r) * 64'(s4_t0_r);
      s5_p1_r      <= 64'(s4_t1_r) * 64'(s4_t1_r);
      s5_side_r    <= s4_side_r;
      s6_sum_r     <= s5_p0_r + s5_p1_r;
      s6_side_r    <= s5_side_r;
    end
  end

  // second root
  logic        q2_vld;
  logic [31:0] q2_root;
  psdf_side_t  q2_side;

  psdf_isqrt u_root2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s6_vld_r),
    .in_rad   (s6_sum_r),
    .in_side  (s6_side_r),
    .out_vld  (q2_vld),
    .out_root (q2_root),
    .out_side (q2_side)
  );

  // --------------------------------------------------------------------------
  // S7: shape distance
  // --------------------------------------------------------------------------
  logic signed [35:0] r1s, r2s, inner_s, q_s, dy_s, sa_s, sb_s, th_s;
  logic signed [35:0] boxd, sphd, absb, abss, cmx, cmn, dsel;

  assign r1s     = $signed({4'b0000, q2_side.r1});
  assign r2s     = $signed({4'b0000, q2_root});
  assign inner_s = {{2{q2_side.inner[33]}}, q2_side.inner};
  assign q_s     = {{2{q2_side.q[33]}}, q2_side.q};
  assign dy_s    = {{2{q2_side.dy[33]}}, q2_side.dy};
  assign sa_s    = $signed({5'b00000, size_a_r});
  assign sb_s    = $signed({5'b00000, size_b_r});
  assign th_s    = $signed({5'b00000, shell_r});
  assign boxd    = inner_s + r1s;
  assign sphd    = r1s - sa_s;
  assign absb    = boxd[35] ? -boxd : boxd;
  assign abss    = sphd[35] ? -sphd : sphd;
  assign cmx     = (q_s > dy_s) ? q_s : dy_s;
  assign cmn     = cmx[35] ? cmx : 36'sd0;

  always_comb begin
    case (q2_side.shape)
      SHAPE_SPHERE:  dsel = sphd;
      SHAPE_TORUS:   dsel = r2s - sb_s;
      SHAPE_CYL:     dsel = cmn + r2s;
      SHAPE_HSPHERE: dsel = abss - th_s;
      SHAPE_HBOX:    dsel = absb - th_s;
      default:       dsel = boxd;
    endcase
  end

  logic               s7_vld_r;
  logic signed [35:0] s7_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s7_vld_r <= 1'b0;
    else if (en) s7_vld_r <= q2_vld;
  end

  always_ff @(posedge clk) begin
    if (en) s7_d_r <= dsel;
  end

  // --------------------------------------------------------------------------
  // S8: sign, tolerance, saturation -> output register
  // --------------------------------------------------------------------------
  logic signed [37:0] dn, e;
  logic               ovf;
  logic signed [31:0] dist_nxt;

  assign dn  = inv_r ? -{{2{s7_d_r[35]}}, s7_d_r} : {{2{s7_d_r[35]}}, s7_d_r};
  assign e   = dn - {{6{tol_r[31]}}, tol_r};
  assign ovf = !((e[37:31] == 7'h00) || (e[37:31] == 7'h7f));

  always_comb begin
    if (!ovf)        dist_nxt = e[31:0];
    else if (e[37])  dist_nxt = 32'sh8000_0000;
    else             dist_nxt = 32'sh7fff_ffff;
  end

  logic               out_vld_r;
  logic signed [31:0] out_dist_r;
  logic               out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= s7_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_dist_r <= dist_nxt;
      out_sat_r  <= ovf;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_signed_distance = out_dist_r;
  assign out_saturated       = out_sat_r;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_signed_distance == 32'sh7fff_ffff) || (out_signed_distance == 32'sh8000_0000))
    else $error("saturated beat not at a range limit");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top : self-checking bench for the primitive SDF evaluator
// Streams points through the block under several shape and size settings,
// predicts every distance with an in-bench model and compares each result
// beat field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import psdf_pkg::*;

  localparam int LATENCY  = 72;
  localparam int WD_LIMIT = 5000;
  localparam logic [2:0] REG_INDEX_UNUSED = 3'd7;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_point_x;
  logic signed [31:0] in_point_y;
  logic signed [31:0] in_point_z;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_signed_distance;
  logic               out_saturated;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;

  primitive_sdf_eval dut (.*);

  // shadow copy of the register file
  logic [2:0]         m_shape;
  logic               m_inv;
  logic signed [63:0] m_tol;
  logic signed [63:0] m_sa, m_sb, m_sc, m_shell;

  typedef struct packed {
    logic signed [31:0] sdist;
    logic               sat;
  } dist_t;

  dist_t  dist_q[$];
  int     n_err;
  int     n_pts;
  int     n_res;
  int     n_sat;
  int     idle_cnt;
  bit     quiet;   // when set the result side never stalls

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---- predictor ------------------------------------------------------------
  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b   = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [63:0] mag(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [63:0] norm_of(logic signed [63:0] a,
      logic signed [63:0] b, logic signed [63:0] c);
    logic [63:0] ua, ub, uc;
    ua = mag(a);
    ub = mag(b);
    uc = mag(c);
    return $signed(floor_root(ua * ua + ub * ub + uc * uc));
  endfunction

  function automatic logic signed [63:0] pos(logic signed [63:0] v);
    return v > 0 ? v : 64'sd0;
  endfunction

  function automatic logic signed [63:0] box_of(logic signed [63:0] x,
      logic signed [63:0] y, logic signed [63:0] z);
    logic signed [63:0] dx, dy, dz, m;
    dx = mag(x) - m_sa;
    dy = mag(y) - m_sb;
    dz = mag(z) - m_sc;
    m  = dx > dy ? dx : dy;
    m  = m > dz ? m : dz;
    if (m > 0) m = 0;
    return m + norm_of(pos(dx), pos(dy), pos(dz));
  endfunction

  function automatic dist_t predict_dist(logic signed [31:0] px,
      logic signed [31:0] py, logic signed [31:0] pz);
    logic signed [63:0] x, y, z, d, q, dy, m;
    dist_t r;
    x = px;
    y = py;
    z = pz;
    case (m_shape)
      SHAPE_SPHERE: d = norm_of(x, y, z) - m_sa;
      SHAPE_TORUS: begin
        q = norm_of(x, 0, z) - m_sa;
        d = norm_of(q, y, 0) - m_sb;
      end
      SHAPE_CYL: begin
        q  = norm_of(x, 0, z) - m_sa;
        dy = mag(y) - m_sb;
        m  = q > dy ? q : dy;
        if (m > 0) m = 0;
        d = m + norm_of(pos(q), pos(dy), 0);
      end
      SHAPE_HSPHERE: d = mag(norm_of(x, y, z) - m_sa) - m_shell;
      SHAPE_HBOX:    d = mag(box_of(x, y, z)) - m_shell;
      default:       d = box_of(x, y, z);   // unused codes fall back to box
    endcase
    if (m_inv) d = -d;
    d = d - m_tol;
    r.sat = 1'b0;
    if (d > 64'sh7FFF_FFFF) begin
      d     = 64'sh7FFF_FFFF;
      r.sat = 1'b1;
    end else if (d < -64'sh8000_0000) begin
      d     = -64'sh8000_0000;
      r.sat = 1'b1;
    end
    r.sdist = d[31:0];
    return r;
  endfunction

  // ---- drivers --------------------------------------------------------------
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SHAPE: m_shape = val[2:0];
      REG_INV:   m_inv   = val[0];
      REG_TOL:   m_tol   = $signed(val);
      REG_SIZEA: m_sa    = {33'd0, val[30:0]};
      REG_SIZEB: m_sb    = {33'd0, val[30:0]};
      REG_SIZEC: m_sc    = {33'd0, val[30:0]};
      REG_SHELL: m_shell = {33'd0, val[30:0]};
      default: ;
    endcase
    @(posedge clk);
  endtask

  // in_valid stays high after a beat until the next call decides on a gap
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
      bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    in_point_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    dist_q = {dist_q, predict_dist(x, y, z)};
    n_pts++;
  endtask

  // waits until every prediction is consumed, then lets the pipe drain
  task automatic drain();
    in_valid <= 1'b0;
    while (dist_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // ---- result side: stall pattern and checker -------------------------------
  initial begin
    int hold;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) hold = 0;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    dist_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_res++;
      if (dist_q.size() == 0) begin
        $error("result beat with nothing pending");
        n_err++;
      end else begin
        e = dist_q.pop_front();
        if (e.sat) n_sat++;
        if (out_signed_distance !== e.sdist) begin
          $error("signed_distance: expected %0d, got %0d", e.sdist, out_signed_distance);
          n_err++;
        end
        if (out_saturated !== e.sat) begin
          $error("saturated: expected %0b, got %0b", e.sat, out_saturated);
          n_err++;
        end
      end
    end
  end

  // watchdog: any accepted beat resets the idle count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WD_LIMIT) begin
      $display("watchdog expired");
      $display("Mismatches found");
      $finish;
    end
  end

  // ---- random value helpers -------------------------------------------------
  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0:       return $urandom();                              // full range
      1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  function automatic logic [31:0] rnd_size();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'd0;
      2:       return $urandom();   // bit 31 ignored by the block
      default: return $urandom_range(0, 32'h0003_0000);
    endcase
  endfunction

  // ---- tests ----------------------------------------------------------------
  task automatic test_reset_box();
    // register defaults: unit box, no tolerance
    send_point(0, 0, 0);
    send_point(32'h0002_0000, 0, 0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000);
    drain();
  endtask

  task automatic test_each_shape();
    // every code incl. the unused ones, with a shell on the hollow shapes
    write_reg(REG_SHELL, 32'h0000_4000);
    write_reg(REG_SIZEB, 32'h0000_8000);
    for (int s = 0; s < 8; s++) begin
      write_reg(REG_SHAPE, s);
      send_point(0, 0, 0);
      send_point(32'h0001_8000, 32'hFFFF_0000, 32'h0000_4000);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      drain();
    end
  endtask

  task automatic test_saturation();
    // huge sizes and tolerance drive results to both range limits
    write_reg(REG_SHAPE, SHAPE_BOX);
    write_reg(REG_INV, 1);
    write_reg(REG_TOL, 32'h7FFF_FFFF);
    write_reg(REG_SIZEA, 32'h7FFF_FFFF);
    write_reg(REG_SIZEB, 32'h7FFF_FFFF);
    write_reg(REG_SIZEC, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 0, 32'h7FFF_FFFF);
    send_point(0, 0, 0);
    drain();
    write_reg(REG_INV, 0);
    write_reg(REG_TOL, 32'h8000_0000);
    write_reg(REG_SIZEA, 0);
    write_reg(REG_SIZEB, 0);
    write_reg(REG_SIZEC, 0);
    write_reg(REG_INDEX_UNUSED, 32'hDEAD_BEEF);  // index beyond the list: no effect
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(0, 0, 0);
    drain();
  endtask

  task automatic test_random_phases();
    int n;
    for (int ph = 0; ph < 35; ph++) begin
      write_reg(REG_SHAPE, $urandom_range(0, 7));
      write_reg(REG_INV, $urandom_range(0, 1));
      write_reg(REG_TOL, $urandom_range(0, 2) == 0 ? $urandom()
                          : $signed($urandom_range(0, 32'h2_0000)) - 32'sh1_0000);
      write_reg(REG_SIZEA, rnd_size());
      write_reg(REG_SIZEB, rnd_size());
      write_reg(REG_SIZEC, rnd_size());
      write_reg(REG_SHELL, rnd_size());
      quiet = (ph % 5 == 4);
      n = 50;
      for (int i = 0; i < n; i++)
        send_point(rnd_coord(), rnd_coord(), rnd_coord(), quiet);
      drain();
    end
    quiet = 0;
  endtask

  initial begin
    n_err      = 0;
    n_pts      = 0;
    n_res      = 0;
    n_sat      = 0;
    quiet      = 0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_point_x = '0;
    in_point_y = '0;
    in_point_z = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    m_shape    = SHAPE_BOX;
    m_inv      = 1'b0;
    m_tol      = 0;
    m_sa       = 64'sd65536;
    m_sb       = 64'sd65536;
    m_sc       = 64'sd65536;
    m_shell    = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_box();
    test_each_shape();
    test_saturation();
    test_random_phases();

    $display("%0d points sent, %0d results checked, %0d of them clamped",
             n_pts, n_res, n_sat);
    $display("covered all shape codes, sign inversion, tolerance and size extremes");
    if (n_err == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/psdf_pkg.sv
rtl/psdf_isqrt.sv
rtl/primitive_sdf_eval.sv
verif/tb_top.sv
